[rtl/bvd_pkg.sv]
`timescale 1ns / 1ps

package bvd_pkg;

  // Upper bound on spans per direction that any build may use
  localparam int unsigned MaxSpanLimit = 12;

  // Saturation limit of products and sums
  localparam logic signed [63:0] AccLim = 64'sh3FFF_FFFF_FFFF_FFFF;

  // Command codes
  localparam logic [1:0] CMD_WRITE      = 2'd0;
  localparam logic [1:0] CMD_EVAL_WORLD = 2'd1;
  localparam logic [1:0] CMD_EVAL_PARAM = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_BOX_MIN_X    = 3'd0;
  localparam logic [2:0] CFG_BOX_MIN_Y    = 3'd1;
  localparam logic [2:0] CFG_BOX_MIN_Z    = 3'd2;
  localparam logic [2:0] CFG_INV_EXTENT_X = 3'd3;
  localparam logic [2:0] CFG_INV_EXTENT_Y = 3'd4;
  localparam logic [2:0] CFG_INV_EXTENT_Z = 3'd5;
  localparam logic [2:0] CFG_SPAN_COUNTS  = 3'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         ctrl_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [19:0] param_s;
    logic signed [19:0] param_t;
    logic signed [19:0] param_u;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PARAM,
    ST_WMUL,
    ST_LREAD,
    ST_LMUL,
    ST_KNEXT,
    ST_TMUL,
    ST_SMUL,
    ST_OUT
  } st_e;

  // Binomial coefficients, row n column k
  typedef logic [MaxSpanLimit:0][MaxSpanLimit:0][9:0] binom_tab_t;

  function automatic binom_tab_t make_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n <= MaxSpanLimit; n++) begin
      t[n][0] = 10'd1;
      for (int k = 1; k <= n; k++) begin
        t[n][k] = t[n-1][k-1] + ((k < n) ? t[n-1][k] : 10'd0);
      end
    end
    return t;
  endfunction

  localparam binom_tab_t Binom = make_binom();

endpackage

[rtl/bvd_ram.sv]
`timescale 1ns / 1ps

module bvd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bvd_mul.sv]
`timescale 1ns / 1ps

module bvd_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               q24_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o,
  output logic               sat_o
);
  import bvd_pkg::*;

  logic               busy_q, busy_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [63:0]        am_q, am_d, bm_q, bm_d;
  logic               neg_q, neg_d, q24_q, q24_d;
  logic [63:0]        pp_q, pp_d;
  logic [1:0]         sh_q, sh_d;
  logic [127:0]       sum_q, sum_d;
  logic               done_q, done_d, sat_q, sat_d;
  logic signed [63:0] res_q, res_d;
  logic [31:0]        ah, bh;
  logic [127:0]       rf;
  logic               sat16;
  logic [63:0]        rmag;

  // Pick the halves for this partial product
  assign ah = cnt_q[1] ? am_q[63:32] : am_q[31:0];
  assign bh = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];

  // Round the finished product and, in Q16 mode, saturate it
  assign rf    = sum_q >> 16;
  assign sat16 = rf > 128'(AccLim);
  assign rmag  = q24_q ? sum_q[87:24] : (sat16 ? AccLim : rf[63:0]);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    am_d   = am_q;
    bm_d   = bm_q;
    neg_d  = neg_q;
    q24_d  = q24_q;
    pp_d   = pp_q;
    sh_d   = sh_q;
    sum_d  = sum_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      am_d   = a_i[63] ? 64'(-a_i) : 64'(a_i);
      bm_d   = b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_d  = a_i[63] ^ b_i[63];
      q24_d  = q24_i;
      sum_d  = q24_i ? (128'd1 << 23) : (128'd1 << 15);
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q < 3'd4) begin
        pp_d = ah * bh;
        sh_d = 2'(cnt_q[1]) + 2'(cnt_q[0]);
      end
      if (cnt_q != 3'd0 && cnt_q != 3'd5) begin
        sum_d = sum_q + (128'(pp_q) << (7'd32 * 7'(sh_q)));
      end
      if (cnt_q == 3'd5) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        sat_d  = sat16 & ~q24_q;
        res_d  = neg_q ? -$signed(rmag) : $signed(rmag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    am_q  <= am_d;
    bm_q  <= bm_d;
    neg_q <= neg_d;
    q24_q <= q24_d;
    pp_q  <= pp_d;
    sh_q  <= sh_d;
    sum_q <= sum_d;
    sat_q <= sat_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

[rtl/bezier_volume_deformer_core.sv]
`timescale 1ns / 1ps

// Trivariate Bezier free-form deformation engine.
// Input channel (in_valid_i / in_stall_o / in_req_i) carries one request per
// accepted cycle. A write request stores a control point in the lattice RAM
// and is accepted while idle, giving no result. An evaluate request (world or
// parameter point) produces one result on the output channel.
// Every multiply goes through one shared 32x32 partial-product unit; the next
// one issues only once the last 64-bit product is ready. An evaluation runs 3
// parameter maps (world points only), sum over axes of n*(n+1) weight
// multiplies, then 3 per lattice point, 3 per (i,j) row and 3 per i plane,
// plus a read and an advance state per point. in_stall_o is high for the
// whole evaluation.
// The result sits in an output register until taken; while the receiver
// stalls, the next request may be accepted but its result waits for the slot.
// Reset clears the control state and loads the register defaults; the lattice
// holds no valid contents until written. The user must write configuration
// via cfg_we_i / cfg_idx_i / cfg_data_i only while idle, unchecked by the block.

module bezier_volume_deformer_core #(
  parameter int unsigned MAX_SPAN   = 4,
  parameter int unsigned MAX_POINTS = 125
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bvd_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bvd_pkg::out_rsp_t  out_rsp_o
);
  import bvd_pkg::*;

  localparam int unsigned SW   = $clog2(MAX_SPAN + 1);
  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned IWL  = $clog2((MAX_SPAN + 1) ** 3 + 1);
  localparam int unsigned IW   = (IWL > AW + 1) ? IWL : AW + 1;

  // Saturating add of two limited values
  function automatic logic [64:0] sadd(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_3FFF_FFFF_FFFF_FFFF) return {1'b1, AccLim};
    if (s < -65'sh0_3FFF_FFFF_FFFF_FFFF) return {1'b1, -AccLim};
    return {1'b0, s[63:0]};
  endfunction

  // Clamp a span field to 1..MAX_SPAN
  function automatic logic [SW-1:0] span_clamp(input logic [3:0] v);
    if (v == 4'd0) return SW'(1);
    if (32'(v) > MAX_SPAN) return SW'(MAX_SPAN);
    return SW'(v);
  endfunction

  // Configuration registers
  logic signed [31:0] box_min_q [3];
  logic [31:0]        inv_ext_q [3];
  logic [11:0]        spans_q;

  // Sequencer and datapath registers
  st_e                state_q, state_d;
  logic               issued_q, issued_d;
  logic signed [31:0] coord_q [3], coord_d [3];
  logic signed [19:0] prm_q [3], prm_d [3];
  logic [SW-1:0]      n_q [3], n_d [3];
  logic [1:0]         axis_q, axis_d, cc_q, cc_d;
  logic [SW-1:0]      kk_q, kk_d, ee_q, ee_d;
  logic [SW-1:0]      i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic signed [63:0] v_q, v_d;
  logic signed [63:0] w_q [3][MAX_SPAN+1], w_d [3][MAX_SPAN+1];
  logic signed [63:0] p2_q [3], p2_d [3], p1_q [3], p1_d [3];
  logic signed [63:0] acc_q [3], acc_d [3];
  logic               clip_q, clip_d;
  logic               ov_q, ov_d;
  out_rsp_t           rsp_q, rsp_d;

  // Shared multiplier interface
  logic               mul_start, mul_q24, mul_done, mul_sat;
  logic signed [63:0] mul_a, mul_b, mul_res;

  // Lattice RAM interface
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [95:0]        ram_rdata;

  logic               in_acc, is_eval, out_free, idx_ok;
  logic signed [63:0] xw;
  logic [64:0]        sres;
  logic signed [31:0] oclip [3];
  logic [2:0]         oflag;
  logic signed [31:0] lat [3];

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign is_eval  = in_req_i.cmd == CMD_EVAL_WORLD || in_req_i.cmd == CMD_EVAL_PARAM;
  assign out_free = ~ov_q | ~out_stall_i;
  assign idx_ok   = 32'(idx_q) < MAX_POINTS;
  assign xw       = 64'(prm_q[axis_q]);
  assign lat[0]   = ram_rdata[31:0];
  assign lat[1]   = ram_rdata[63:32];
  assign lat[2]   = ram_rdata[95:64];

  // Clip accumulated coordinates to Q16.16
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      oflag[c] = 1'b0;
      oclip[c] = acc_q[c][31:0];
      if (acc_q[c] > 64'sh7FFF_FFFF) begin
        oflag[c] = 1'b1;
        oclip[c] = 32'sh7FFF_FFFF;
      end else if (acc_q[c] < -64'sh8000_0000) begin
        oflag[c] = 1'b1;
        oclip[c] = -32'sh8000_0000;
      end
    end
  end

  // Saturating add of the product into the selected accumulator
  always_comb begin
    case (state_q)
      ST_LMUL: sres = sadd(p2_q[cc_q], mul_res);
      ST_TMUL: sres = sadd(p1_q[cc_q], mul_res);
      ST_SMUL: sres = sadd(acc_q[cc_q], mul_res);
      default: sres = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_eval) begin
          state_d = (in_req_i.cmd == CMD_EVAL_WORLD) ? ST_PARAM : ST_WMUL;
        end
      end
      ST_PARAM: begin
        if (mul_done && axis_q == 2'd2) state_d = ST_WMUL;
      end
      ST_WMUL: begin
        if (mul_done && ee_q == SW'(n_q[axis_q] - 1'b1) && kk_q == n_q[axis_q]
            && axis_q == 2'd2) begin
          state_d = ST_LREAD;
        end
      end
      ST_LREAD: state_d = idx_ok ? ST_LMUL : ST_KNEXT;
      ST_LMUL: begin
        if (mul_done && cc_q == 2'd2) state_d = ST_KNEXT;
      end
      ST_KNEXT: state_d = (k_q == n_q[2]) ? ST_TMUL : ST_LREAD;
      ST_TMUL: begin
        if (mul_done && cc_q == 2'd2) state_d = (j_q == n_q[1]) ? ST_SMUL : ST_LREAD;
      end
      ST_SMUL: begin
        if (mul_done && cc_q == 2'd2) state_d = (i_q == n_q[0]) ? ST_OUT : ST_LREAD;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    issued_d = issued_q;
    coord_d  = coord_q;
    prm_d    = prm_q;
    n_d      = n_q;
    axis_d   = axis_q;
    cc_d     = cc_q;
    kk_d     = kk_q;
    ee_d     = ee_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    idx_d    = idx_q;
    v_d      = v_q;
    w_d      = w_q;
    p2_d     = p2_q;
    p1_d     = p1_q;
    acc_d    = acc_q;
    clip_d   = clip_q;
    rsp_d    = rsp_q;
    ov_d     = ov_q & out_stall_i;
    in_stall_o = state_q != ST_IDLE;
    mul_start  = 1'b0;
    mul_q24    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = AW'(in_req_i.ctrl_index);

    // Issue one multiply per step, wait for its result
    if (state_q == ST_PARAM || state_q == ST_WMUL || state_q == ST_LMUL ||
        state_q == ST_TMUL || state_q == ST_SMUL) begin
      mul_start = ~issued_q;
      issued_d  = ~mul_done;
      if (mul_done) clip_d = clip_q | mul_sat;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_req_i.cmd == CMD_WRITE &&
            32'(in_req_i.ctrl_index) < MAX_POINTS) begin
          ram_we = 1'b1;
        end
        if (in_acc && is_eval) begin
          coord_d[0] = in_req_i.coord_x;
          coord_d[1] = in_req_i.coord_y;
          coord_d[2] = in_req_i.coord_z;
          prm_d[0]   = in_req_i.param_s;
          prm_d[1]   = in_req_i.param_t;
          prm_d[2]   = in_req_i.param_u;
          n_d[0]     = span_clamp(spans_q[3:0]);
          n_d[1]     = span_clamp(spans_q[7:4]);
          n_d[2]     = span_clamp(spans_q[11:8]);
          axis_d = '0;
          cc_d   = '0;
          kk_d   = '0;
          ee_d   = '0;
          i_d    = '0;
          j_d    = '0;
          k_d    = '0;
          idx_d  = '0;
          v_d    = 64'sd65536;
          clip_d = 1'b0;
          for (int c = 0; c < 3; c++) begin
            p2_d[c]  = '0;
            p1_d[c]  = '0;
            acc_d[c] = '0;
          end
        end
      end
      ST_PARAM: begin
        mul_q24 = 1'b1;
        mul_a   = 64'(coord_q[axis_q]) - 64'(box_min_q[axis_q]);
        mul_b   = $signed({32'd0, inv_ext_q[axis_q]});
        if (mul_done) begin
          if (mul_res > 64'sd524287) begin
            prm_d[axis_q] = 20'sd524287;
            clip_d = 1'b1;
          end else if (mul_res < -64'sd524288) begin
            prm_d[axis_q] = -20'sd524288;
            clip_d = 1'b1;
          end else begin
            prm_d[axis_q] = mul_res[19:0];
          end
          axis_d = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
        end
      end
      ST_WMUL: begin
        // k factors of x, then n-k factors of (1 - x)
        mul_a = v_q;
        mul_b = (ee_q < kk_q) ? xw : 64'sd65536 - xw;
        if (mul_done) begin
          v_d = mul_res;
          if (ee_q == SW'(n_q[axis_q] - 1'b1)) begin
            w_d[axis_q][kk_q] = mul_res;
            ee_d = '0;
            if (kk_q == n_q[axis_q]) begin
              kk_d   = '0;
              v_d    = 64'sd65536;
              axis_d = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
            end else begin
              kk_d = kk_q + 1'b1;
              v_d  = $signed(64'(Binom[4'(n_q[axis_q])][4'(kk_q + 1'b1)]) << 16);
            end
          end else begin
            ee_d = ee_q + 1'b1;
          end
        end
      end
      ST_LREAD: begin
        ram_re = idx_ok;
        cc_d   = '0;
      end
      ST_LMUL: begin
        mul_a = 64'(lat[cc_q]);
        mul_b = w_q[2][k_q];
        if (mul_done) begin
          p2_d[cc_q] = sres[63:0];
          clip_d = clip_q | mul_sat | sres[64];
          cc_d = cc_q + 2'd1;
        end
      end
      ST_KNEXT: begin
        idx_d = idx_q + 1'b1;
        cc_d  = '0;
        k_d   = (k_q == n_q[2]) ? '0 : k_q + 1'b1;
      end
      ST_TMUL: begin
        mul_a = p2_q[cc_q];
        mul_b = w_q[1][j_q];
        if (mul_done) begin
          p1_d[cc_q] = sres[63:0];
          p2_d[cc_q] = '0;
          clip_d = clip_q | mul_sat | sres[64];
          cc_d = (cc_q == 2'd2) ? 2'd0 : cc_q + 2'd1;
          if (cc_q == 2'd2) j_d = (j_q == n_q[1]) ? '0 : j_q + 1'b1;
        end
      end
      ST_SMUL: begin
        mul_a = p1_q[cc_q];
        mul_b = w_q[0][i_q];
        if (mul_done) begin
          acc_d[cc_q] = sres[63:0];
          p1_d[cc_q]  = '0;
          clip_d = clip_q | mul_sat | sres[64];
          cc_d = (cc_q == 2'd2) ? 2'd0 : cc_q + 2'd1;
          if (cc_q == 2'd2 && i_q != n_q[0]) i_d = i_q + 1'b1;
        end
      end
      ST_OUT: begin
        // Load the result once the output slot is free
        if (out_free) begin
          ov_d            = 1'b1;
          rsp_d.out_x     = oclip[0];
          rsp_d.out_y     = oclip[1];
          rsp_d.out_z     = oclip[2];
          rsp_d.saturated = clip_q | (|oflag);
        end
      end
      default: begin
        issued_d = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_min_q[a] <= '0;
        inv_ext_q[a] <= 32'd16777216;
      end
      spans_q <= 12'd546;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOX_MIN_X:    box_min_q[0] <= cfg_data_i;
        CFG_BOX_MIN_Y:    box_min_q[1] <= cfg_data_i;
        CFG_BOX_MIN_Z:    box_min_q[2] <= cfg_data_i;
        CFG_INV_EXTENT_X: inv_ext_q[0] <= cfg_data_i;
        CFG_INV_EXTENT_Y: inv_ext_q[1] <= cfg_data_i;
        CFG_INV_EXTENT_Z: inv_ext_q[2] <= cfg_data_i;
        CFG_SPAN_COUNTS:  spans_q      <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ov_q     <= ov_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    prm_q   <= prm_d;
    n_q     <= n_d;
    axis_q  <= axis_d;
    cc_q    <= cc_d;
    kk_q    <= kk_d;
    ee_q    <= ee_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    idx_q   <= idx_d;
    v_q     <= v_d;
    w_q     <= w_d;
    p2_q    <= p2_d;
    p1_q    <= p1_d;
    acc_q   <= acc_d;
    clip_q  <= clip_d;
    rsp_q   <= rsp_d;
  end

  bvd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .q24_i   (mul_q24),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  bvd_ram #(
    .WIDTH (96),
    .DEPTH (MAX_POINTS)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_req_i.coord_z, in_req_i.coord_y, in_req_i.coord_x}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = ov_q;
  assign out_rsp_o   = rsp_q;

endmodule
